// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PBSD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pbsd check failed");

// next-cycle implication, checked out of reset
`define PBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pbsd check failed");

`endif

// ===== rtl/core/pbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbsd_pkg
// binary32 helpers for the point-box distance core: compare, add, multiply
// ----------------------------------------------------------------------------
`default_nettype none

package pbsd_pkg;

  localparam int unsigned FpW = 32;
  localparam int unsigned SigW = 50;
  localparam logic [FpW-1:0] CanonNan = 32'h7FC0_0000;
  localparam logic [FpW-1:0] PosZero = 32'h0000_0000;
  localparam logic [7:0] ExpMax = 8'hFF;
  localparam logic signed [11:0] Bias = 12'sd127;

  function automatic logic fp_is_nan(input logic [FpW-1:0] a);
    return (a[30:23] == ExpMax) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [FpW-1:0] a);
    return (a[30:23] == ExpMax) && (a[22:0] == 23'd0);
  endfunction

  // ordered less-than, false on nan and on two zeros
  function automatic logic fp_lt(input logic [FpW-1:0] a, input logic [FpW-1:0] b);
    logic [FpW-1:0] ka;
    logic [FpW-1:0] kb;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    if (fp_is_nan(a) || fp_is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b0;
    return ka < kb;
  endfunction

  // second operand on equal or unordered
  function automatic logic [FpW-1:0] fp_min(input logic [FpW-1:0] a,
                                            input logic [FpW-1:0] b);
    return fp_lt(a, b) ? a : b;
  endfunction

  // value = m * 2^(e - 127 - 48), rounded to nearest even
  function automatic logic [FpW-1:0] round_pack(input logic sgn,
                                                input logic signed [11:0] e,
                                                input logic [SigW-1:0] m);
    logic [5:0] lz;
    logic [SigW-1:0] mn;
    logic signed [11:0] en;
    logic [11:0] sh;
    logic st;
    logic [7:0] ex;
    logic inc;
    logic [30:0] body;
    lz = 6'd0;
    for (int i = 0; i < SigW; i++) begin
      if (m[i]) lz = 6'(SigW - 1 - i);
    end
    mn = m << lz;
    en = e + 12'sd1 - $signed({6'd0, lz});
    if (m == '0) return {sgn, 31'd0};
    if (en >= 12'sd255) return {sgn, ExpMax, 23'd0};
    if (en < 12'sd1) begin
      sh = 12'(12'sd1 - en);
      if (sh > 12'(SigW)) sh = 12'(SigW);
      st = |(mn & ((50'd1 << sh) - 50'd1));
      mn = (mn >> sh) | {49'd0, st};
      ex = 8'd0;
    end else begin
      ex = en[7:0];
    end
    inc = mn[25] & ((|mn[24:0]) | mn[26]);
    body = {ex, mn[48:26]} + {30'd0, inc};
    return {sgn, body};
  endfunction

  function automatic logic [FpW-1:0] fp_mul(input logic [FpW-1:0] a,
                                            input logic [FpW-1:0] b);
    logic sgn;
    logic [23:0] ma;
    logic [23:0] mb;
    logic signed [11:0] e;
    logic [47:0] p;
    sgn = a[31] ^ b[31];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    e = $signed({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]})
      + $signed({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - Bias;
    p = ma * mb;
    if (fp_is_nan(a) || fp_is_nan(b)) return CanonNan;
    if (fp_is_inf(a) || fp_is_inf(b)) begin
      if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) return CanonNan;
      return {sgn, ExpMax, 23'd0};
    end
    if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) return {sgn, 31'd0};
    return round_pack(sgn, e, {p, 2'b00});
  endfunction

  function automatic logic [FpW-1:0] fp_add(input logic [FpW-1:0] a,
                                            input logic [FpW-1:0] b);
    logic [FpW-1:0] x;
    logic [FpW-1:0] y;
    logic [7:0] ex;
    logic [7:0] ey;
    logic [7:0] d;
    logic [SigW-1:0] mx;
    logic [SigW-1:0] my;
    logic st;
    logic [SigW-1:0] s;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d = ex - ey;
    mx = {1'b0, x[30:23] != 8'd0, x[22:0], 25'd0};
    my = {1'b0, y[30:23] != 8'd0, y[22:0], 25'd0};
    if (d >= 8'(SigW)) begin
      st = |my;
      my = '0;
    end else begin
      st = |(my & ((50'd1 << d) - 50'd1));
      my = my >> d;
    end
    my = my | {49'd0, st};
    s = (x[31] == y[31]) ? (mx + my) : (mx - my);
    if (fp_is_nan(a) || fp_is_nan(b)) return CanonNan;
    if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) return CanonNan;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return {a[31] & b[31], 31'd0};
    if (s == '0) return PosZero;
    return round_pack(x[31], $signed({4'd0, ex}), s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/point_box_signed_squared_distance_core.sv =====
// ----------------------------------------------------------------------------
// point_box_signed_squared_distance_core
// signed squared distance from a 3d point to an axis-aligned box, binary32
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and gives one result item
// per item, in order. Each item passes the five register stages: the six
// per-axis subtracts, the per-axis min and outside test, the squarers, the
// first add with the inside negation, and the final add into the output
// register. A stall on the output freezes the whole pipeline at once, so
// in_stall is high exactly while a result waits in the output register and
// out_stall is high. All arithmetic is binary32 round-to-nearest-even with
// subnormals kept; any nan result comes out as 0x7FC00000. Positive results
// are outside distances, negative results mean the point lies inside the
// box, and zero can come from either.
`default_nettype none

`include "assert_macros.svh"

module point_box_signed_squared_distance_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_point_x,
  input  wire logic [31:0] in_point_y,
  input  wire logic [31:0] in_point_z,
  input  wire logic [31:0] in_box_min_x,
  input  wire logic [31:0] in_box_min_y,
  input  wire logic [31:0] in_box_min_z,
  input  wire logic [31:0] in_box_max_x,
  input  wire logic [31:0] in_box_max_y,
  input  wire logic [31:0] in_box_max_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_signed_sq_distance
);

  // valid bits travel with the data
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  // pipeline advance: everything moves unless a result is held at the output
  logic adv;
  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 1: distances to each face
  logic [31:0] dmn_r [3];
  logic [31:0] dmx_r [3];
  logic [31:0] pt [3];
  logic [31:0] lo [3];
  logic [31:0] hi [3];
  assign pt = '{in_point_x, in_point_y, in_point_z};
  assign lo = '{in_box_min_x, in_box_min_y, in_box_min_z};
  assign hi = '{in_box_max_x, in_box_max_y, in_box_max_z};

  // stage 2: per-axis min, outside flags, inside min
  logic [31:0] d_r [3];
  logic [31:0] m_r;
  logic        out2_r;
  logic [31:0] d_nxt [3];
  logic [2:0]  neg_nxt;
  logic [31:0] m_nxt;

  // stage 3: squares
  logic [31:0] sq_r [3];
  logic [31:0] ms_r;
  logic        out3_r;

  // stage 4: first sum and inside value
  logic [31:0] acc_r;
  logic [31:0] sq2_r;
  logic [31:0] ins_r;
  logic        out4_r;

  logic [31:0] res_r;
  logic        outside_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]   = pbsd_pkg::fp_min(dmn_r[i], dmx_r[i]);
      neg_nxt[i] = pbsd_pkg::fp_lt(d_nxt[i], pbsd_pkg::PosZero);
    end
    // inside min order is (x, z) then y
    m_nxt = pbsd_pkg::fp_min(pbsd_pkg::fp_min(d_nxt[0], d_nxt[2]), d_nxt[1]);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dmn_r[i] <= pbsd_pkg::fp_add(pt[i], lo[i] ^ 32'h8000_0000);
        dmx_r[i] <= pbsd_pkg::fp_add(hi[i], pt[i] ^ 32'h8000_0000);
        d_r[i]   <= neg_nxt[i] ? d_nxt[i] : pbsd_pkg::PosZero;
        sq_r[i]  <= pbsd_pkg::fp_mul(d_r[i], d_r[i]);
      end
      m_r       <= m_nxt;
      out2_r    <= |neg_nxt;
      ms_r      <= pbsd_pkg::fp_mul(m_r, m_r);
      out3_r    <= out2_r;
      acc_r     <= pbsd_pkg::fp_add(sq_r[0], sq_r[1]);
      sq2_r     <= sq_r[2];
      // 0 - m*m
      ins_r     <= pbsd_pkg::fp_add(pbsd_pkg::PosZero, ms_r ^ 32'h8000_0000);
      out4_r    <= out3_r;
      res_r     <= out4_r ? pbsd_pkg::fp_add(acc_r, sq2_r) : ins_r;
      outside_r <= out4_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_signed_sq_distance = res_r;

  // an outside result is a sum of squares, never negative
  `PBSD_ASSERT_IMPL(a_outside_nonneg, clk, rst_n, out_valid_r && outside_r, !res_r[31])
  // a held stage keeps its item while the output is blocked
  `PBSD_ASSERT_NEXT(a_hold_v4, clk, rst_n, v4_r && !adv, v4_r)
  // stage 2 only fills from stage 1
  `PBSD_ASSERT_IMPL(a_v2_src, clk, rst_n, v2_r && !$past(v2_r), $past(v1_r))

endmodule

`default_nettype wire

// ===== bench/tb_point_box_signed_squared_distance_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_box_signed_squared_distance_core
// self-checking bench for the binary32 point-to-box signed squared distance
// ----------------------------------------------------------------------------
// A short table of hand-picked queries comes first, then random queries.
// Accepted queries without a typed result are predicted in double precision
// with a rounding step to binary32 after each operation, exact here because
// double precision is wide enough that one rounding of +, - or * is never
// spoiled. Results are compared in order against the queue. Both sides idle
// and stall at random in the first two phases. At the start of the last the
// receiver holds off for a long stretch, so the pipeline fills.

module tb_point_box_signed_squared_distance_core;

  localparam int NumRandom = 1800;
  localparam int WatchLimit = 2000;
  localparam int HoldCycles = 300;
  localparam int NumDirected = 12;
  localparam logic [31:0] QNan = 32'h7FC0_0000;
  localparam logic [31:0] PosInf = 32'h7F80_0000;
  localparam logic [31:0] NegInf = 32'hFF80_0000;
  localparam logic [31:0] MaxFin = 32'h7F7F_FFFF;
  localparam logic [31:0] One = 32'h3F80_0000;
  localparam logic [31:0] Half = 32'h3F00_0000;

  // field order: point xyz, box min xyz, box max xyz
  typedef logic [8:0][31:0] query_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_signed_sq_distance;
  query_t      cur_query = '0;

  logic [31:0] dist_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 29;
  int          recv_stall_pct = 87;
  bit          hold_go = 1'b0;
  bit          hold_started = 1'b0;
  int          hold_left = 0;

  query_t      dir_tab[NumDirected];
  logic [31:0] dir_exp[NumDirected];
  bit          dir_known[NumDirected];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_box_signed_squared_distance_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_point_x             (cur_query[0]),
    .in_point_y             (cur_query[1]),
    .in_point_z             (cur_query[2]),
    .in_box_min_x           (cur_query[3]),
    .in_box_min_y           (cur_query[4]),
    .in_box_min_z           (cur_query[5]),
    .in_box_max_x           (cur_query[6]),
    .in_box_max_y           (cur_query[7]),
    .in_box_max_z           (cur_query[8]),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_signed_sq_distance (out_signed_sq_distance)
  );

  // binary32 bits to an exact double
  function automatic real widen(input logic [31:0] w);
    logic [10:0] de;
    real r;
    if (w[30:23] == 8'hFF) begin
      return $bitstoreal({w[31], 11'h7FF, w[22:0], 29'd0});
    end
    if (w[30:23] == 8'd0) begin
      r = $itor(w[22:0]) * (2.0 ** (-149));
      // keeps the sign of zero too
      return w[31] ? -r : r;
    end
    de = 11'(int'(w[30:23]) - 127 + 1023);
    return $bitstoreal({w[31], de, w[22:0], 29'd0});
  endfunction

  // round a double to binary32, nearest even, subnormals kept
  function automatic logic [31:0] narrow(input real r);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] halfway;
    logic [30:0] body;
    int fe;
    int sh;
    logic inc;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF) begin
      if (b[51:0] != 52'd0) return QNan;
      return {b[63], 8'hFF, 23'd0};
    end
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    fe = int'(b[62:52]) - 1023 + 127;
    if (fe >= 255) return {b[63], 8'hFF, 23'd0};
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 54) return {b[63], 31'd0};
    m = {11'd0, 1'b1, b[51:0]};
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 64'd1);
    halfway = 64'd1 << (sh - 1);
    inc = (rem > halfway) || ((rem == halfway) && q[0]);
    // a carry out of the mantissa bumps the exponent, up to infinity
    body = {(fe >= 1) ? 8'(fe) : 8'd0, q[22:0]} + {30'd0, inc};
    return {b[63], body};
  endfunction

  function automatic real op_sub(input real a, input real b);
    return widen(narrow(a - b));
  endfunction

  function automatic real op_mul(input real a, input real b);
    return widen(narrow(a * b));
  endfunction

  function automatic real op_add(input real a, input real b);
    return widen(narrow(a + b));
  endfunction

  // second operand on a tie or an unordered pair
  function automatic real pick_min(input real a, input real b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [31:0] predict_distance(input query_t q);
    real d[3];
    real sq[3];
    real m;
    bit outside;
    outside = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d[i] = pick_min(op_sub(widen(q[i]), widen(q[3+i])),
                      op_sub(widen(q[6+i]), widen(q[i])));
      // a nan axis compares false here and never counts as outside
      if (d[i] < 0.0) begin
        sq[i] = op_mul(d[i], d[i]);
        outside = 1'b1;
      end else begin
        sq[i] = 0.0;
      end
    end
    if (outside) return narrow(op_add(op_add(sq[0], sq[1]), sq[2]));
    m = pick_min(pick_min(d[0], d[2]), d[1]);
    return narrow(0.0 - op_mul(m, m));
  endfunction

  // one coordinate: mostly ordinary values, with zeros, subnormals,
  // infinities, nans, huge values and raw bits mixed in
  function automatic logic [31:0] rand_coord();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return {1'($urandom), 8'($urandom_range(118, 134)), 23'($urandom)};
    if (k < 78) return {1'($urandom), 31'd0};
    if (k < 84) return {1'($urandom), 8'd0, 23'($urandom)};
    if (k < 88) return {1'($urandom), 8'hFF, 23'd0};
    if (k < 91) return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
    if (k < 95) return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
    return 32'($urandom);
  endfunction

  function automatic query_t make_query();
    query_t q;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    // raw noise on every field now and then
    if ($urandom_range(0, 99) < 10) begin
      for (int i = 0; i < 9; i++) q[i] = 32'($urandom);
      return q;
    end
    for (int i = 0; i < 3; i++) begin
      lo = rand_coord();
      hi = rand_coord();
      // mostly well-formed boxes, some inverted ones
      if ((widen(lo) > widen(hi)) && ($urandom_range(0, 99) < 85)) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      q[i] = rand_coord();
      q[3+i] = lo;
      q[6+i] = hi;
    end
    return q;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_query(input query_t q, input bit known, input logic [31:0] typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cur_query <= q;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    dist_q.push_back(known ? typed : predict_distance(q));
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold when asked
  always @(negedge clk) begin
    if (hold_go && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item %h", out_signed_sq_distance);
      end else begin
        want = dist_q.pop_front();
        if (want !== out_signed_sq_distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %h actual %h", want,
                     out_signed_sq_distance);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // inside a unit box at its center: 0 - 0.5^2
    dir_tab[0] = {One, One, One, 96'd0, Half, Half, Half};
    dir_exp[0] = 32'hBE80_0000;
    dir_known[0] = 1'b1;
    // one unit outside along x
    dir_tab[1] = {One, One, One, 96'd0, Half, Half, 32'h4000_0000};
    dir_exp[1] = One;
    dir_known[1] = 1'b1;
    // degenerate box at the origin, point on it
    dir_tab[2] = '0;
    dir_exp[2] = 32'h0000_0000;
    dir_known[2] = 1'b1;
    // nan point gives the canonical nan
    dir_tab[3] = {One, One, One, 96'd0, QNan, 32'h7FA0_0001, 32'hFFC0_0000};
    dir_exp[3] = QNan;
    dir_known[3] = 1'b1;
    // unbounded box: infinite inside distance
    dir_tab[4] = {PosInf, PosInf, PosInf, NegInf, NegInf, NegInf, 96'd0};
    dir_exp[4] = NegInf;
    dir_known[4] = 1'b1;
    // square overflows to infinity
    dir_tab[5] = {One, One, One, 96'd0, Half, Half, MaxFin};
    dir_exp[5] = PosInf;
    dir_known[5] = 1'b1;
    // point at infinity along x, box max at infinity along z
    dir_tab[6] = {PosInf, One, One, 96'd0, Half, Half, PosInf};
    // subnormal box and point
    dir_tab[7] = {32'h0000_0002, 32'h007F_FFFF, 32'h0000_0003, 96'd0,
                  32'h8000_0001, 32'h0000_0001, 32'h0000_0001};
    // signed zeros: box max at negative zero
    dir_tab[8] = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 96'd0,
                  32'h8000_0000, 64'd0};
    // all-ones and sign-cleared all-ones fields
    dir_tab[9] = {9{32'hFFFF_FFFF}};
    dir_tab[10] = {9{32'h7FFF_FFFF}};
    // point inside the box, extremes of the finite range
    dir_tab[11] = {MaxFin, MaxFin, 32'h0080_0000, {3{32'hFF7F_FFFF}},
                   32'hFF7F_FFFF, 32'h8000_0001, 32'h0000_0001};
    for (int i = 6; i < NumDirected; i++) begin
      dir_exp[i] = '0;
      dir_known[i] = 1'b0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumDirected; i++) offer_query(dir_tab[i], dir_known[i], dir_exp[i]);

    for (int n = 0; n < NumRandom; n++) begin
      // phase changes: idle weights swap, then no idling with one long hold
      if (n == NumRandom / 3) begin
        send_idle_pct = 87;
        recv_stall_pct = 29;
      end
      if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 1'b1;
      end
      offer_query(make_query(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (dist_q.size() != 0) @(posedge clk);
    // pipeline is five stages deep, let any stray result show
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
